// ===== hw/rtl/hrp_pkg.sv =====
// Shared types, constants and helpers for the HTTP request-head parser.
// No dependencies.
package hrp_pkg;

    localparam int REQ_LINE_MAX_DEF    = 256;
    localparam int HEADER_LINE_MAX_DEF = 128;
    localparam int ETAG_MAX_DEF        = 64;
    localparam int TARGET_MAX_DEF      = 128;
    localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

    // wide enough for any size in the parameter ranges
    localparam int CW = 11;

    localparam int INM_LEN  = 14;
    localparam int GET_LEN  = 4;
    localparam int POST_LEN = 5;

    localparam logic [7:0] INM_WORD [INM_LEN] = '{8'h49, 8'h66, 8'h2D, 8'h4E, 8'h6F,
        8'h6E, 8'h65, 8'h2D, 8'h4D, 8'h61, 8'h74, 8'h63, 8'h68, 8'h3A};
    localparam logic [7:0] GET_WORD  [GET_LEN]  = '{8'h47, 8'h45, 8'h54, 8'h20};
    localparam logic [7:0] POST_WORD [POST_LEN] = '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20};

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [1:0] {
        K_BYTE   = 2'd0,
        K_CLEAR  = 2'd1,
        K_RD_TGT = 2'd2,
        K_RD_TAG = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_DONE    = 3'd1,
        ST_LINE_OV = 3'd2,
        ST_BAD_TGT = 3'd3,
        ST_SIZE    = 3'd4,
        ST_READ    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        M_GET   = 2'd0,
        M_POST  = 2'd1,
        M_OTHER = 2'd2
    } t_method;

    // classified request passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [6:0] idx;
        logic       cr;
        logic       lf;
        logic       sp;
        logic       blank;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== hw/rtl/hrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hrp_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/hrp_front.sv =====
// Front end: accepts requests, classifies them, holds them in a 2-entry queue.
// Depends on hrp_pkg.
module hrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_data_byte,
    input  logic [6:0]    i_read_index,
    input  logic          i_pop,
    output hrp_pkg::t_qhead o_head
);
    import hrp_pkg::*;

    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    t_item          r_q [QD];
    logic [QW-1:0]  r_wp, r_rp;
    logic [QW:0]    r_cnt;
    t_item          w_item;
    logic           w_push;

    always_comb begin
        w_item.kind  = t_kind'(i_action);
        w_item.data  = i_data_byte;
        w_item.idx   = i_read_index;
        w_item.cr    = (i_data_byte == CH_CR);
        w_item.lf    = (i_data_byte == CH_LF);
        w_item.sp    = (i_data_byte == CH_SP);
        w_item.blank = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB);
    end

    assign o_ready = (r_cnt != (QW+1)'(QD));
    assign w_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QW'(QD-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QW'(QD-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(w_push) - (QW+1)'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];
endmodule

// ===== hw/rtl/hrp_back.sv =====
// Back end: parser state, line/tag stores, tag copy sweep and result register.
// Depends on hrp_pkg and hrp_ram.
module hrp_back #(
    parameter int REQ_LINE_MAX    = hrp_pkg::REQ_LINE_MAX_DEF,
    parameter int HEADER_LINE_MAX = hrp_pkg::HEADER_LINE_MAX_DEF,
    parameter int ETAG_MAX        = hrp_pkg::ETAG_MAX_DEF,
    parameter int TARGET_MAX      = hrp_pkg::TARGET_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrp_pkg::t_qhead i_head,
    output logic            o_pop,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_status,
    output logic [1:0]      o_method,
    output logic [6:0]      o_target_length,
    output logic [5:0]      o_etag_length,
    output logic [7:0]      o_read_byte
);
    import hrp_pkg::*;

    localparam int RW = $clog2(REQ_LINE_MAX);
    localparam int HW = $clog2(HEADER_LINE_MAX);
    localparam int EW = $clog2(ETAG_MAX);
    localparam int TW = $clog2(TARGET_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CP_RD = 4'b0100,
        S_CP_WR = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_max;
    logic [RW-1:0] r_rcount, n_rcount;
    logic [HW-1:0] r_hcount, n_hcount, r_hb, n_hb, r_he, n_he;
    logic [EW-1:0] r_tagn, n_tagn;
    logic [15:0] r_total, n_total;
    logic [1:0] r_phase, n_phase;
    logic r_first, n_first, r_done, n_done;
    logic [1:0] r_method, n_method;
    logic [2:0] r_tstart, n_tstart;
    logic [TW-1:0] r_tlen, n_tlen;
    logic r_gm, n_gm, r_pm, n_pm, r_hm, n_hm, r_hnb, n_hnb;
    logic [TW-1:0] r_len0, n_len0, r_len4, n_len4, r_len5, n_len5;
    logic r_stp0, n_stp0, r_stp4, n_stp4, r_stp5, n_stp5;
    logic [EW-1:0] r_cp_idx, n_cp_idx, r_cp_n, n_cp_n;
    logic [HW-1:0] r_cp_src, n_cp_src;
    logic r_rd_tag, n_rd_tag, r_rd_hit, n_rd_hit;
    logic r_ov, n_ov;
    logic [2:0] r_ost, n_ost;
    logic [7:0] r_orb, n_orb;

    // memory ports
    logic          w_req_we, w_hdr_we, w_tag_we;
    logic [RW-1:0] w_req_raddr;
    logic [HW-1:0] w_hdr_raddr;
    logic [EW-1:0] w_tag_raddr;
    logic [7:0]    w_req_rdata, w_hdr_rdata, w_tag_rdata;

    hrp_ram #(.W(8), .D(REQ_LINE_MAX)) u_req_ram (
        .i_clk(i_clk), .i_we(w_req_we), .i_waddr(r_rcount), .i_wdata(i_head.item.data),
        .i_raddr(w_req_raddr), .o_rdata(w_req_rdata));
    hrp_ram #(.W(8), .D(HEADER_LINE_MAX)) u_hdr_ram (
        .i_clk(i_clk), .i_we(w_hdr_we), .i_waddr(r_hcount), .i_wdata(i_head.item.data),
        .i_raddr(w_hdr_raddr), .o_rdata(w_hdr_rdata));
    hrp_ram #(.W(8), .D(ETAG_MAX)) u_tag_ram (
        .i_clk(i_clk), .i_we(w_tag_we), .i_waddr(r_cp_idx), .i_wdata(w_hdr_rdata),
        .i_raddr(w_tag_raddr), .o_rdata(w_tag_rdata));

    t_item         it;
    logic          w_clr, w_is_get, w_is_post;
    logic [CW-1:0] w_n, w_flen;
    logic [TW-1:0] w_sel_len;

    assign it = i_head.item;
    assign o_pop = (r_state == S_IDLE) && i_head.valid && (!r_ov || i_ready);

    always_comb begin
        n_state = r_state;   n_rcount = r_rcount; n_hcount = r_hcount;
        n_hb = r_hb;         n_he = r_he;         n_tagn = r_tagn;
        n_total = r_total;   n_phase = r_phase;   n_first = r_first;
        n_done = r_done;     n_method = r_method; n_tstart = r_tstart;
        n_tlen = r_tlen;     n_gm = r_gm;         n_pm = r_pm;
        n_hm = r_hm;         n_hnb = r_hnb;       n_len0 = r_len0;
        n_len4 = r_len4;     n_len5 = r_len5;     n_stp0 = r_stp0;
        n_stp4 = r_stp4;     n_stp5 = r_stp5;     n_cp_idx = r_cp_idx;
        n_cp_n = r_cp_n;     n_cp_src = r_cp_src; n_rd_tag = r_rd_tag;
        n_rd_hit = r_rd_hit; n_ost = r_ost;       n_orb = r_orb;
        n_ov = r_ov && !i_ready;
        w_clr = 1'b0;
        w_req_we = 1'b0; w_hdr_we = 1'b0; w_tag_we = 1'b0;
        w_req_raddr = RW'(CW'(r_tstart) + CW'(it.idx));
        w_hdr_raddr = r_cp_src;
        w_tag_raddr = EW'(it.idx);
        w_is_get  = (r_rcount >= RW'(GET_LEN)) && r_gm;
        w_is_post = (r_rcount >= RW'(POST_LEN)) && r_pm;
        w_sel_len = w_is_get ? r_len4 : (w_is_post ? r_len5 : r_len0);
        w_n = '0;
        w_flen = CW'(r_he) - CW'(r_hb);

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_orb = '0;
                    case (it.kind)
                        K_CLEAR: begin
                            w_clr = 1'b1;
                            n_ov = 1'b1; n_ost = ST_BUSY;
                        end
                        K_RD_TGT: begin
                            n_rd_tag = 1'b0;
                            n_rd_hit = CW'(it.idx) < CW'(r_tlen);
                            n_state = S_READ;
                        end
                        K_RD_TAG: begin
                            n_rd_tag = 1'b1;
                            n_rd_hit = CW'(it.idx) < CW'(r_tagn);
                            n_state = S_READ;
                        end
                        default: begin
                            n_ov = 1'b1;
                            n_ost = ST_BUSY;
                            if (r_done) begin
                                n_ost = ST_DONE;
                            end else begin
                                if (r_total != 16'hFFFF) begin
                                    n_total = r_total + 16'd1;
                                end
                                if (!r_first) begin
                                    if (it.lf) begin
                                        n_first = 1'b1;
                                    end else if (!it.cr) begin
                                        if (CW'(r_rcount) + 1'b1 >= CW'(REQ_LINE_MAX)) begin
                                            w_clr = 1'b1;
                                            n_ost = ST_LINE_OV;
                                        end else begin
                                            w_req_we = 1'b1;
                                            n_rcount = r_rcount + 1'b1;
                                            if (r_rcount < RW'(GET_LEN)) begin
                                                n_gm = r_gm && (it.data == GET_WORD[r_rcount[1:0]]);
                                            end
                                            if (r_rcount < RW'(POST_LEN)) begin
                                                n_pm = r_pm && (it.data == POST_WORD[r_rcount[2:0]]);
                                            end
                                            // target length seen from each candidate start
                                            if (!r_stp0) begin
                                                if (it.sp) n_stp0 = 1'b1;
                                                else if (r_len0 != TW'(TARGET_MAX))
                                                    n_len0 = r_len0 + 1'b1;
                                            end
                                            if (!r_stp4 && r_rcount >= RW'(GET_LEN)) begin
                                                if (it.sp) n_stp4 = 1'b1;
                                                else if (r_len4 != TW'(TARGET_MAX))
                                                    n_len4 = r_len4 + 1'b1;
                                            end
                                            if (!r_stp5 && r_rcount >= RW'(POST_LEN)) begin
                                                if (it.sp) n_stp5 = 1'b1;
                                                else if (r_len5 != TW'(TARGET_MAX))
                                                    n_len5 = r_len5 + 1'b1;
                                            end
                                        end
                                    end
                                end else if (it.lf) begin
                                    // end of a header line: capture If-None-Match value
                                    if (CW'(r_hcount) >= CW'(INM_LEN) && r_hm) begin
                                        w_n = r_hnb ? w_flen : '0;
                                        if (w_n > CW'(ETAG_MAX - 1)) w_n = CW'(ETAG_MAX - 1);
                                        n_tagn = EW'(w_n);
                                        if (w_n != '0) begin
                                            n_cp_idx = '0;
                                            n_cp_n = EW'(w_n);
                                            n_cp_src = r_hb;
                                            n_state = S_CP_RD;
                                        end
                                    end
                                    n_hcount = '0; n_hm = 1'b1; n_hnb = 1'b0;
                                end else if (!it.cr) begin
                                    if (CW'(r_hcount) + 1'b1 < CW'(HEADER_LINE_MAX)) begin
                                        w_hdr_we = 1'b1;
                                        n_hcount = r_hcount + 1'b1;
                                        if (CW'(r_hcount) < CW'(INM_LEN)) begin
                                            n_hm = r_hm && (fold(it.data) ==
                                                            fold(INM_WORD[r_hcount[3:0]]));
                                        end else if (!it.blank) begin
                                            if (!r_hnb) n_hb = r_hcount;
                                            n_hnb = 1'b1;
                                            n_he = r_hcount + 1'b1;
                                        end
                                    end
                                end
                                if (n_ost == ST_BUSY) begin
                                    case (r_phase)
                                        2'd0: n_phase = it.cr ? 2'd1 : 2'd0;
                                        2'd1: n_phase = it.lf ? 2'd2 : (it.cr ? 2'd1 : 2'd0);
                                        2'd2: n_phase = it.cr ? 2'd3 : 2'd0;
                                        default: n_phase = it.cr ? 2'd1 : 2'd0;
                                    endcase
                                    if (r_phase == 2'd3 && it.lf) begin
                                        n_phase = r_phase;
                                        if (w_sel_len == '0 ||
                                            CW'(w_sel_len) >= CW'(TARGET_MAX)) begin
                                            w_clr = 1'b1;
                                            n_ost = ST_BAD_TGT;
                                        end else begin
                                            n_method = w_is_get ? M_GET :
                                                       (w_is_post ? M_POST : M_OTHER);
                                            n_tstart = w_is_get ? 3'(GET_LEN) :
                                                       (w_is_post ? 3'(POST_LEN) : 3'd0);
                                            n_tlen = w_sel_len;
                                            n_done = 1'b1;
                                            n_ost = ST_DONE;
                                        end
                                    end else if (n_total >= r_max) begin
                                        w_clr = 1'b1;
                                        n_ost = ST_SIZE;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_ov = 1'b1;
                n_ost = ST_READ;
                n_orb = r_rd_hit ? (r_rd_tag ? w_tag_rdata : w_req_rdata) : 8'd0;
                n_state = S_IDLE;
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                w_tag_we = 1'b1;
                n_cp_idx = r_cp_idx + 1'b1;
                n_cp_src = r_cp_src + 1'b1;
                n_state = (r_cp_idx + 1'b1 == r_cp_n) ? S_IDLE : S_CP_RD;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_clr) begin
            n_state = S_IDLE;
            n_rcount = '0; n_hcount = '0; n_tagn = '0; n_total = '0; n_phase = '0;
            n_first = 1'b0; n_done = 1'b0; n_method = '0; n_tstart = '0; n_tlen = '0;
            n_gm = 1'b1; n_pm = 1'b1; n_hm = 1'b1; n_hnb = 1'b0;
            n_len0 = '0; n_len4 = '0; n_len5 = '0;
            n_stp0 = 1'b0; n_stp4 = 1'b0; n_stp5 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hb <= n_hb;     r_he <= n_he;     r_cp_idx <= n_cp_idx;
        r_cp_n <= n_cp_n; r_cp_src <= n_cp_src;
        r_rd_tag <= n_rd_tag; r_rd_hit <= n_rd_hit;
        r_ost <= n_ost;   r_orb <= n_orb;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_max <= MAX_BYTES_RST;
            r_rcount <= '0; r_hcount <= '0; r_tagn <= '0; r_total <= '0; r_phase <= '0;
            r_first <= 1'b0; r_done <= 1'b0; r_method <= '0; r_tstart <= '0; r_tlen <= '0;
            r_gm <= 1'b1; r_pm <= 1'b1; r_hm <= 1'b1; r_hnb <= 1'b0;
            r_len0 <= '0; r_len4 <= '0; r_len5 <= '0;
            r_stp0 <= 1'b0; r_stp4 <= 1'b0; r_stp5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max <= i_cfg_wdata;
            r_rcount <= n_rcount; r_hcount <= n_hcount; r_tagn <= n_tagn;
            r_total <= n_total; r_phase <= n_phase; r_first <= n_first;
            r_done <= n_done; r_method <= n_method; r_tstart <= n_tstart;
            r_tlen <= n_tlen; r_gm <= n_gm; r_pm <= n_pm; r_hm <= n_hm;
            r_hnb <= n_hnb; r_len0 <= n_len0; r_len4 <= n_len4; r_len5 <= n_len5;
            r_stp0 <= n_stp0; r_stp4 <= n_stp4; r_stp5 <= n_stp5;
            r_ov <= n_ov;
        end
    end

    // result fields follow the parser state as it stood after the request
    logic [1:0]  r_om;
    logic [6:0]  r_otl;
    logic [5:0]  r_oel;

    always_ff @(posedge i_clk) begin
        if (n_ov && !(r_ov && !i_ready)) begin
            r_om  <= n_method;
            r_otl <= 7'(n_tlen);
            r_oel <= 6'(n_tagn);
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ost;
    assign o_method        = r_om;
    assign o_target_length = r_otl;
    assign o_etag_length   = r_oel;
    assign o_read_byte     = r_orb;
endmodule

// ===== hw/rtl/http_request_head_parser.sv =====
// HTTP request-head parser for one connection: one result per request.
// The back end takes one request at a time; a target or tag read passes
// through a read state, and the LF that closes an If-None-Match line copies
// up to ETAG_MAX-1 tag characters from the header line RAM, each through a
// read and a write state. A 2-entry queue in front accepts one request per
// cycle while room remains, and the result register holds one finished result
// for the consumer. The byte limit register resets to 4096 and may be rewritten
// while idle. No clearing pass after reset; stores are only read where written.
// Depends on hrp_pkg, hrp_front, hrp_back, hrp_ram.
module http_request_head_parser #(
    parameter int REQ_LINE_MAX    = hrp_pkg::REQ_LINE_MAX_DEF,
    parameter int HEADER_LINE_MAX = hrp_pkg::HEADER_LINE_MAX_DEF,
    parameter int ETAG_MAX        = hrp_pkg::ETAG_MAX_DEF,
    parameter int TARGET_MAX      = hrp_pkg::TARGET_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // max_request_bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // data_byte[7:0], read_index[14:8], zero[15]
    input  logic [1:0]  i_s_tuser,     // action[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // method[1:0], target_length[8:2],
                                       // etag_length[14:9], read_byte[22:15], zero[23]
    output logic [2:0]  o_m_tuser      // status[2:0]
);
    import hrp_pkg::*;

    t_qhead     w_head;
    logic       w_pop;
    logic [1:0] w_method;
    logic [6:0] w_tlen;
    logic [5:0] w_elen;
    logic [7:0] w_rbyte;

    hrp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_action(i_s_tuser), .i_data_byte(i_s_tdata[7:0]),
        .i_read_index(i_s_tdata[14:8]),
        .i_pop(w_pop), .o_head(w_head));

    hrp_back #(
        .REQ_LINE_MAX(REQ_LINE_MAX), .HEADER_LINE_MAX(HEADER_LINE_MAX),
        .ETAG_MAX(ETAG_MAX), .TARGET_MAX(TARGET_MAX)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_head(w_head), .o_pop(w_pop),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_status(o_m_tuser), .o_method(w_method),
        .o_target_length(w_tlen), .o_etag_length(w_elen),
        .o_read_byte(w_rbyte));

    assign o_m_tdata = {1'b0, w_rbyte, w_elen, w_tlen, w_method};
endmodule

// ===== hw/rtl/hrp_checker.sv =====
// Port-level checks for the HTTP request-head parser, bound to the top level.
// Depends on hrp_pkg and http_request_head_parser.
module hrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);
    import hrp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_rbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_READ |-> o_m_tdata[22:15] == 8'd0)
        else $error("read byte set outside a read reply");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_LINE_OV || o_m_tuser == ST_BAD_TGT ||
                       o_m_tuser == ST_SIZE)
        |-> o_m_tdata[14:0] == 15'd0)
        else $error("error result carries stale fields");
endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for http_request_head_parser: queue-fed stream driver,
// result monitor against an in-bench parser model, random idling on both sides.
// Depends on hrp_pkg and the RTL of http_request_head_parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hrp_pkg::*;

    localparam int RL_MAX   = 256;
    localparam int HL_MAX   = 128;
    localparam int TAG_MAX  = 64;
    localparam int TGT_MAX  = 128;
    localparam int WDOG_LIM = 2000;   // longest legal quiet spell is the long receiver hold

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [6:0] idx;
    } t_req;

    typedef struct {
        t_status    status;
        logic [1:0] method;
        logic [6:0] tlen;
        logic [5:0] elen;
        logic [7:0] rbyte;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // data_byte[7:0], read_index[14:8], zero[15]
    logic [1:0]  s_tuser = '0;    // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // method[1:0], target_length[8:2], etag_length[14:9],
                                  // read_byte[22:15], zero[23]
    logic [2:0]  m_tuser;         // status[2:0]

    http_request_head_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser model: mirrors the head parser state, one reply per request
    // ------------------------------------------------------------------
    logic [7:0]  line_buf [RL_MAX];
    logic [7:0]  hdr_buf  [HL_MAX];
    logic [7:0]  tag_buf  [TAG_MAX];
    int          line_cnt, hdr_cnt, tag_cnt, rx_total, crlf_phase, tgt_start, tgt_cnt;
    bit          line_done, head_done;
    logic [1:0]  meth;
    logic [15:0] byte_limit = MAX_BYTES_RST;

    t_req   pend_q  [$];   // requests waiting for the driver
    t_reply reply_q [$];   // replies the block still owes
    int     errs = 0;
    int     n_accepted = 0;
    bit     calm = 0;      // no idling in the closing phase

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function void parser_clear();
        line_cnt = 0; hdr_cnt = 0; tag_cnt = 0; rx_total = 0; crlf_phase = 0;
        line_done = 0; head_done = 0; meth = M_GET; tgt_start = 0; tgt_cnt = 0;
    endfunction

    // header line closed: capture If-None-Match value, blanks trimmed
    function void grab_tag();
        int b, e, n;
        if (hdr_cnt < INM_LEN) return;
        for (int i = 0; i < INM_LEN; i++)
            if (lower(hdr_buf[i]) != lower(INM_WORD[i])) return;
        b = INM_LEN;
        e = hdr_cnt;
        while (b < e && blank(hdr_buf[b])) b++;
        while (e > b && blank(hdr_buf[e-1])) e--;
        n = e - b;
        if (n > TAG_MAX - 1) n = TAG_MAX - 1;
        for (int i = 0; i < n; i++) tag_buf[i] = hdr_buf[b+i];
        tag_cnt = n;
    endfunction

    function t_status close_head();
        int st, len;
        bit g, p;
        g = line_cnt >= GET_LEN;
        for (int i = 0; i < GET_LEN; i++) if (g && line_buf[i] != GET_WORD[i]) g = 0;
        p = line_cnt >= POST_LEN;
        for (int i = 0; i < POST_LEN; i++) if (p && line_buf[i] != POST_WORD[i]) p = 0;
        if (g) begin
            meth = M_GET; st = GET_LEN;
        end else if (p) begin
            meth = M_POST; st = POST_LEN;
        end else begin
            meth = M_OTHER; st = 0;
        end
        len = 0;
        while (st + len < line_cnt && line_buf[st+len] != CH_SP) len++;
        if (len == 0 || len >= TGT_MAX) begin
            parser_clear();
            return ST_BAD_TGT;
        end
        tgt_start = st;
        tgt_cnt = len;
        head_done = 1;
        return ST_DONE;
    endfunction

    function t_status rx_byte(input logic [7:0] c);
        if (head_done) return ST_DONE;
        if (rx_total < 16'hFFFF) rx_total++;
        if (!line_done) begin
            if (c == CH_LF) begin
                line_done = 1;
            end else if (c != CH_CR) begin
                if (line_cnt + 1 >= RL_MAX) begin
                    parser_clear();
                    return ST_LINE_OV;
                end
                line_buf[line_cnt++] = c;
            end
        end else if (c == CH_LF) begin
            grab_tag();
            hdr_cnt = 0;
        end else if (c != CH_CR && hdr_cnt + 1 < HL_MAX) begin
            hdr_buf[hdr_cnt++] = c;
        end
        // CR LF CR LF tracker
        case (crlf_phase)
            0: crlf_phase = (c == CH_CR) ? 1 : 0;
            1: crlf_phase = (c == CH_LF) ? 2 : ((c == CH_CR) ? 1 : 0);
            2: crlf_phase = (c == CH_CR) ? 3 : 0;
            default: begin
                if (c == CH_LF) return close_head();
                crlf_phase = (c == CH_CR) ? 1 : 0;
            end
        endcase
        if (rx_total >= byte_limit) begin
            parser_clear();
            return ST_SIZE;
        end
        return ST_BUSY;
    endfunction

    function void predict_reply(input t_req r);
        t_reply x;
        x.rbyte = '0;
        case (r.kind)
            K_BYTE:  x.status = rx_byte(r.data);
            K_CLEAR: begin
                parser_clear();
                x.status = ST_BUSY;
            end
            K_RD_TGT: begin
                x.status = ST_READ;
                if (r.idx < tgt_cnt && tgt_start + r.idx < RL_MAX)
                    x.rbyte = line_buf[tgt_start + r.idx];
            end
            default: begin
                x.status = ST_READ;
                if (r.idx < tag_cnt) x.rbyte = tag_buf[r.idx];
            end
        endcase
        x.method = meth;
        x.tlen   = tgt_cnt[6:0];
        x.elen   = tag_cnt[5:0];
        reply_q.push_back(x);
    endfunction

    // ------------------------------------------------------------------
    // Driver: new request offered at the falling edge after acceptance
    // ------------------------------------------------------------------
    bit s_fire;
    int s_idle = 0;

    always @(posedge i_clk) s_fire <= s_tvalid && s_tready;

    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && (!s_tvalid || s_fire)) begin
            if (s_idle > 0) begin
                s_idle = s_idle - 1;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                r = pend_q.pop_front();
                predict_reply(r);   // predicted in offer order, same as accept order
                s_tuser  <= r.kind;
                s_tdata  <= {1'b0, r.idx, r.data};
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0) s_idle = $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold so the input backs up
    // ------------------------------------------------------------------
    int  m_idle = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && n_accepted >= 400) begin
                hold_done = 1;
                hold_left = 250;
                m_tready <= 1'b0;
            end else if (m_idle > 0) begin
                m_idle = m_idle - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_idle = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each reply against the oldest prediction
    // ------------------------------------------------------------------
    int quiet = 0;

    always @(posedge i_clk) begin
        t_reply x;
        if (s_tvalid && s_tready) n_accepted <= n_accepted + 1;
        if (m_tvalid && m_tready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply: status %0d", m_tuser);
                errs++;
            end else begin
                x = reply_q.pop_front();
                if (m_tuser != x.status) begin
                    $error("status: expected %0d, got %0d", x.status, m_tuser);
                    errs++;
                end
                if (m_tdata[1:0] != x.method) begin
                    $error("method: expected %0d, got %0d", x.method, m_tdata[1:0]);
                    errs++;
                end
                if (m_tdata[8:2] != x.tlen) begin
                    $error("target_length: expected %0d, got %0d", x.tlen, m_tdata[8:2]);
                    errs++;
                end
                if (m_tdata[14:9] != x.elen) begin
                    $error("etag_length: expected %0d, got %0d", x.elen, m_tdata[14:9]);
                    errs++;
                end
                if (m_tdata[22:15] != x.rbyte) begin
                    $error("read_byte: expected %0h, got %0h", x.rbyte, m_tdata[22:15]);
                    errs++;
                end
            end
        end
        // watchdog: no handshake on either side for too long
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else if (i_rst_n) begin
            quiet = quiet + 1;
            if (quiet >= WDOG_LIM) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int n_queued = 0;

    task automatic put(input t_kind k, input logic [7:0] d = 8'h00, input logic [6:0] ix = '0);
        t_req r;
        r.kind = k; r.data = d; r.idx = ix;
        pend_q.push_back(r);
        n_queued++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(K_BYTE, s[i]);
    endtask

    task automatic put_eol(input bit bare_lf);
        if (!bare_lf) put(K_BYTE, CH_CR);
        put(K_BYTE, CH_LF);
    endtask

    // printable non-blank character
    function automatic logic [7:0] rnd_char();
        return 8'($urandom_range(33, 126));
    endfunction

    // one request head with random content, then reads, maybe junk bytes, maybe a clear
    task automatic put_request();
        int tl, nh, vl;
        bit lf_only;
        lf_only = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 5))
            0, 1: put_text("GET ");
            2:    put_text("POST ");
            3:    put_text("get ");
            4:    put_text("PUT ");
            default: ;
        endcase
        case ($urandom_range(0, 39))
            0:       tl = 0;
            1:       tl = $urandom_range(120, 140);
            2:       tl = $urandom_range(240, 260);   // may overflow the request line
            default: tl = $urandom_range(1, 14);
        endcase
        for (int i = 0; i < tl; i++) put(K_BYTE, rnd_char());
        if ($urandom_range(0, 4) != 0) put_text(" HTTP/1.1");
        put_eol(0);
        nh = $urandom_range(0, 3);
        for (int h = 0; h < nh; h++) begin
            if ($urandom_range(0, 1)) begin
                for (int i = 0; i < INM_LEN; i++)
                    put(K_BYTE, (INM_WORD[i] >= "A" && $urandom_range(0, 3) == 0) ?
                                INM_WORD[i] ^ 8'h20 : INM_WORD[i]);
                repeat ($urandom_range(0, 2)) put(K_BYTE, $urandom_range(0, 1) ? CH_SP : CH_TAB);
                vl = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 12);
                for (int i = 0; i < vl; i++)
                    put(K_BYTE, ($urandom_range(0, 7) == 0) ? CH_SP : rnd_char());
                repeat ($urandom_range(0, 2)) put(K_BYTE, $urandom_range(0, 1) ? CH_SP : CH_TAB);
            end else begin
                put_text("Host: h");
                repeat ($urandom_range(0, 6)) put(K_BYTE, rnd_char());
            end
            put_eol(lf_only && h == 0);
        end
        put_eol(0);
        repeat ($urandom_range(0, 5))
            put($urandom_range(0, 1) ? K_RD_TGT : K_RD_TAG, 8'($urandom),
                $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(K_BYTE, 8'($urandom));
        if ($urandom_range(0, 1)) put(K_CLEAR, 8'($urandom), 7'($urandom));
    endtask

    task automatic put_noise(input int n);
        repeat (n) put(t_kind'($urandom_range(0, 3)), 8'($urandom), 7'($urandom));
    endtask

    task automatic run_random(input int n);
        int stop;
        stop = n_queued + n;
        while (n_queued < stop) begin
            if ($urandom_range(0, 9) < 8) put_request();
            else put_noise($urandom_range(1, 8));
        end
    endtask

    // wait until every reply is in, then let the back end finish any tag copy
    task automatic drain();
        while (pend_q.size() > 0 || reply_q.size() > 0 || s_tvalid) @(posedge i_clk);
        repeat (2 * TAG_MAX + 4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        byte_limit = v;
    endtask

    initial begin
        parser_clear();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: GET with a folded-case tag line, reads, repeat after done
        put_text("GET /ab HTTP\r\nif-none-MATCH: \t\"q\" \r\n\r\n");
        put(K_RD_TGT, 8'h00, 7'd0);
        put(K_RD_TGT, 8'hFF, 7'd3);
        put(K_RD_TAG, 8'h00, 7'd2);
        put(K_RD_TAG, 8'h00, 7'd127);
        put(K_BYTE, 8'hFF);
        put(K_CLEAR);
        // empty target, other method with zero byte and bare LF
        put_text("POST  x\r\n\r\n");
        put(K_BYTE, 8'h00);
        put_text("Z\n\r\n");
        put(K_RD_TGT, 8'h00, 7'd0);
        put(K_CLEAR);
        run_random(600);
        drain();

        set_limit(16'hFFFF);
        run_random(250);
        drain();
        set_limit(16'd40);
        run_random(150);
        drain();
        set_limit(16'd1);
        put_noise(20);
        drain();
        set_limit(16'd0);
        put_noise(20);
        drain();
        set_limit(MAX_BYTES_RST);
        calm = 1;
        run_random(200);
        drain();

        repeat (20) @(posedge i_clk);
        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
